// File: hdl/harshad_number_test_macros.svh
// Assertion macros shared by the checker of the Harshad number test block.
// Depends on nothing; the including scope must declare clk and rst_n.
`ifndef HARSHAD_NUMBER_TEST_MACROS_SVH
`define HARSHAD_NUMBER_TEST_MACROS_SVH

// Checked at every rising edge outside reset.
`define HNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define HNT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hnt_pkg.sv
// Shared constants and types of the Harshad number test block.
// Depends on nothing.
package hnt_pkg;

  localparam int NUMBER_BITS    = 32;
  localparam int DIGIT_SUM_BITS = 7;
  localparam int NUMBER_WIDTH   = 32;

  localparam int DIGITS     = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH  = 4 * DIGITS;
  localparam int SUM_WIDTH  = $clog2(9 * DIGITS + 1);
  localparam int BIT_CNT_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

  typedef logic [NUMBER_WIDTH-1:0] number_t;
  typedef logic [SUM_WIDTH-1:0]    sum_t;
  typedef logic [BCD_WIDTH-1:0]    bcd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } step_sts_t;

endpackage

// File: hdl/hnt_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on hnt_pkg for the field widths.
interface hnt_in_if;
  logic                           valid;
  logic                           ready;
  logic [hnt_pkg::NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface hnt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              is_niven;
  logic [hnt_pkg::DIGIT_SUM_BITS-1:0] digit_sum;

  modport source (output valid, output is_niven, output digit_sum, input ready);
  modport sink (input valid, input is_niven, input digit_sum, output ready);
endinterface

// File: hdl/hnt_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// Depends on hnt_pkg.
module hnt_bcd (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  hnt_pkg::number_t number,
  output hnt_pkg::bcd_t    bcd,
  output logic             done
);

  hnt_pkg::number_t              sh_r, sh_nxt;
  hnt_pkg::bcd_t                 bcd_r, bcd_nxt, adj;
  logic [hnt_pkg::BIT_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;

  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < hnt_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
    bcd_nxt = {adj[hnt_pkg::BCD_WIDTH-2:0], sh_r[hnt_pkg::NUMBER_WIDTH-1]};
    sh_nxt  = {sh_r[hnt_pkg::NUMBER_WIDTH-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= hnt_pkg::BIT_CNT_W'(hnt_pkg::NUMBER_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hnt_pkg::BIT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= number;
      bcd_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign bcd  = bcd_r;
  assign done = done_r;

endmodule

// File: hdl/hnt_digsum.sv
// Digit accumulator: adds one BCD digit a cycle into the decimal digit sum.
// Depends on hnt_pkg.
module hnt_digsum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hnt_pkg::bcd_t      bcd,
  output hnt_pkg::sum_t      sum,
  output hnt_pkg::step_sts_t sts
);

  hnt_pkg::bcd_t                 sh_r;
  hnt_pkg::sum_t                 acc_r;
  logic [hnt_pkg::DIG_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= hnt_pkg::DIG_CNT_W'(hnt_pkg::DIGITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hnt_pkg::DIG_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= bcd;
      acc_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r >> 4;
      acc_r <= acc_r + hnt_pkg::SUM_WIDTH'(sh_r[3:0]);
    end
  end

  assign sum      = acc_r;
  assign sts.done = done_r;
  assign sts.zero = (acc_r == '0);

endmodule

// File: hdl/hnt_mod.sv
// Bit-serial restoring remainder of the number by the digit sum.
// Depends on hnt_pkg.
module hnt_mod (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  hnt_pkg::number_t   number,
  input  hnt_pkg::sum_t      divisor,
  output hnt_pkg::step_sts_t sts
);

  hnt_pkg::number_t              sh_r;
  hnt_pkg::sum_t                 div_r, rem_r, rem_nxt;
  logic [hnt_pkg::SUM_WIDTH:0]   trial;
  logic [hnt_pkg::BIT_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;

  always_comb begin
    trial = {rem_r, sh_r[hnt_pkg::NUMBER_WIDTH-1]};
    if (trial >= {1'b0, div_r}) begin
      trial = trial - {1'b0, div_r};
    end
    rem_nxt = trial[hnt_pkg::SUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= hnt_pkg::BIT_CNT_W'(hnt_pkg::NUMBER_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hnt_pkg::BIT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= number;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[hnt_pkg::NUMBER_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

// File: hdl/harshad_number_test.sv
// Harshad number test: for each input item the block returns the decimal digit
// sum of the number and a flag that is set when the number is a multiple of that
// sum; zero gives a clear flag and a sum of zero. One item is worked on at a time,
// in three steps from the accepting edge to the result: a bit-serial BCD conversion
// of the number, a digit accumulation of one decimal digit per cycle, then a
// bit-serial restoring remainder of the number by the sum, each step started by the
// done strobe of the one before, and a hold state that loads the result. The result
// sits in an output register, so a new item is taken while the previous result still
// waits for the sink.
// Depends on hnt_pkg, hnt_if, hnt_bcd, hnt_digsum and hnt_mod.
module harshad_number_test (
  input  logic      clk,
  input  logic      rst_n,
  hnt_in_if.sink    in_chan,
  hnt_out_if.source out_chan
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]         state_r, state_nxt;
  hnt_pkg::number_t   n_r;
  hnt_pkg::bcd_t      bcd;
  hnt_pkg::sum_t      sum;
  hnt_pkg::step_sts_t sum_sts, mod_sts;
  logic               bcd_done;
  logic               in_acc, bcd_start, sum_start, mod_start, out_load;
  logic               out_valid_r;
  logic               out_is_niven_r;
  logic [hnt_pkg::DIGIT_SUM_BITS-1:0]                   out_digit_sum_r;
  logic [hnt_pkg::NUMBER_BITS+hnt_pkg::NUMBER_WIDTH-1:0] num_ext;
  logic [hnt_pkg::SUM_WIDTH+hnt_pkg::DIGIT_SUM_BITS-1:0] sum_ext;

  assign num_ext = {hnt_pkg::NUMBER_WIDTH'(0), in_chan.number};
  assign sum_ext = {hnt_pkg::DIGIT_SUM_BITS'(0), sum};

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign bcd_start     = in_acc;
  assign sum_start     = (state_r == ST_CONV) && bcd_done;
  assign mod_start     = (state_r == ST_SUM) && sum_sts.done;
  assign out_load      = (state_r == ST_HOLD) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CONV;
      ST_CONV: if (bcd_done) state_nxt = ST_SUM;
      ST_SUM:  if (sum_sts.done) state_nxt = ST_MOD;
      ST_MOD:  if (mod_sts.done) state_nxt = ST_HOLD;
      ST_HOLD: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r <= num_ext[hnt_pkg::NUMBER_WIDTH-1:0];
    end
    if (out_load) begin
      out_is_niven_r  <= !sum_sts.zero && mod_sts.zero;
      out_digit_sum_r <= sum_ext[hnt_pkg::DIGIT_SUM_BITS-1:0];
    end
  end

  hnt_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .number (num_ext[hnt_pkg::NUMBER_WIDTH-1:0]),
    .bcd    (bcd),
    .done   (bcd_done)
  );

  hnt_digsum u_digsum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sum_start),
    .bcd   (bcd),
    .sum   (sum),
    .sts   (sum_sts)
  );

  hnt_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .number  (n_r),
    .divisor (sum),
    .sts     (mod_sts)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.is_niven  = out_is_niven_r;
  assign out_chan.digit_sum = out_digit_sum_r;

endmodule

// File: hdl/hnt_checker.sv
// Port-level checker for the Harshad number test block, bound to its top level.
// Depends on hnt_pkg, harshad_number_test_macros.svh and harshad_number_test.
`include "harshad_number_test_macros.svh"

module hnt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_is_niven,
  input logic [hnt_pkg::DIGIT_SUM_BITS-1:0] out_digit_sum
);

  `HNT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "Result item dropped while stalled.")
  `HNT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_is_niven) && $stable(out_digit_sum), "Stalled result item changed.")
  `HNT_ASSERT(a_in_busy, in_valid && in_ready |=> !in_ready, "Input taken while an item is in work.")
  `HNT_ASSERT(a_flag_sum, out_valid && out_is_niven |-> out_digit_sum != '0, "Flag set with a zero digit sum.")
  `HNT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "Result valid right after reset.")

endmodule

bind harshad_number_test hnt_checker u_hnt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_is_niven  (out_chan.is_niven),
  .out_digit_sum (out_chan.digit_sum)
);
